@@ hw/rtl/psg_tone_noise_envelope_macros.svh @@
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_macros.svh
// Assertion macros used by the sound generator checker.
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_ENVELOPE_MACROS_SVH
`define PSG_TONE_NOISE_ENVELOPE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sound generator assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define PSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sound generator assertion failed");

// Next-cycle implication that also holds across reset.
`define PSG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sound generator assertion failed");

`endif

@@ hw/rtl/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// psg_pkg
// Register map, command codes, envelope types and the envelope step function.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    localparam int NUM_REGS  = 16;
    localparam int NUM_LANES = 3;

    // command codes (tuser)
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // register indexes
    localparam logic [3:0] REG_NOISE      = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_AMP_BASE   = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_SHAPE      = 4'd13;

    // shape register bits
    localparam int SHAPE_HOLD   = 0;
    localparam int SHAPE_ALT    = 1;
    localparam int SHAPE_ATTACK = 2;
    localparam int SHAPE_CONT   = 3;

    // envelope direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [3:0] LVL_MIN = 4'd0;
    localparam logic [3:0] LVL_MAX = 4'd15;

    typedef struct packed {
        logic [1:0] dir;
        logic [3:0] level;
    } t_env_state;

    // envelope update event broadcast to every channel
    typedef struct packed {
        logic       step;
        logic [3:0] level;
    } t_env_evt;

    function automatic t_env_state env_advance(input t_env_state cur, input logic [7:0] shape);
        t_env_state nxt;
        logic       at_end;
        nxt    = cur;
        at_end = ((cur.dir == DIR_DOWN) && (cur.level == LVL_MIN)) ||
                 ((cur.dir == DIR_UP) && (cur.level == LVL_MAX));
        if (at_end) begin
            if (!shape[SHAPE_CONT]) begin
                nxt.level = LVL_MIN;
                nxt.dir   = DIR_STOP;
            end else begin
                if (shape[SHAPE_ALT]) begin
                    nxt.dir = (cur.dir == DIR_UP) ? DIR_DOWN : DIR_UP;
                end else begin
                    nxt.level = (cur.dir == DIR_UP) ? LVL_MIN : LVL_MAX;
                end
                if (shape[SHAPE_HOLD]) begin
                    nxt.level = (nxt.dir == DIR_UP) ? LVL_MAX : LVL_MIN;
                    nxt.dir   = DIR_STOP;
                end
            end
        end else if (cur.dir == DIR_UP) begin
            nxt.level = cur.level + 4'd1;
        end else if (cur.dir == DIR_DOWN) begin
            nxt.level = cur.level - 4'd1;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psg_tone.sv @@
// ----------------------------------------------------------------------------
// psg_tone
// One channel: tone period counter, square output and channel volume.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone import psg_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_work,         // divided tick for this word
    input  wire logic [7:0] i_fine,
    input  wire logic [3:0] i_coarse,
    input  wire logic [4:0] i_amp,
    input  wire t_env_evt   i_env,
    output logic            o_square_next,
    output logic [3:0]      o_volume_next
);

    logic        r_square;
    logic [15:0] r_count;
    logic [3:0]  r_volume;
    logic        n_square;
    logic [15:0] n_count;
    logic [3:0]  n_volume;
    logic [11:0] w_period_raw;
    logic [15:0] w_period;
    logic        w_wrap;

    assign w_period_raw = {i_coarse, i_fine};
    // zero period acts as one; period is counted in units of 8
    assign w_period = {1'b0, ((w_period_raw == 12'd0) ? 12'd1 : w_period_raw), 3'b000};
    assign w_wrap   = (r_count >= w_period);

    always_comb begin
        n_square = r_square;
        n_count  = r_count;
        n_volume = r_volume;
        if (i_work) begin
            if (!i_amp[4]) begin
                n_volume = i_amp[3:0];
            end else if (i_env.step) begin
                n_volume = i_env.level;
            end
            // silent channel holds its square
            if (i_amp != 5'd0) begin
                if (w_wrap) begin
                    n_square = ~r_square;
                    n_count  = 16'd1;
                end else begin
                    n_count  = r_count + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= 1'b0;
            r_count  <= '0;
            r_volume <= '0;
        end else begin
            r_square <= n_square;
            r_count  <= n_count;
            r_volume <= n_volume;
        end
    end

    assign o_square_next = n_square;
    assign o_volume_next = n_volume;

endmodule

`default_nettype wire

@@ hw/rtl/psg_tone_noise_envelope.sv @@
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope
// Three-channel tone, noise and envelope sound generator, mixer-gated levels.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one command word per transfer: tuser holds the
//   command (tick, register write, envelope restart), tdata the register
//   address and byte. Every accepted word yields exactly one output word on
//   the master channel holding the three gated channel levels.
//   The levels for a word appear in the output register on the cycle
//   after the word is accepted. Throughput is one word per clock; a new word
//   is accepted in every cycle in which the output register is empty or
//   being drained.
//   When the receiver stalls, the output word holds and tready drops once
//   the output register is full, so no word is lost or repeated.
//   A synchronous active-low reset clears the register file, all counters,
//   the envelope and the output valid flag; the noise shifter resets to one.
//   tready stays low while reset is asserted.
//   Only every second tick advances the tone, noise and envelope counters.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone_noise_envelope import psg_pkg::*; #(
    parameter int CHANNELS = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [3:0] reg_addr, [11:4] reg_data
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] command
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata    // [3:0] level_a, [7:4] level_b, [11:8] level_c
);

    logic [7:0]  r_regs [NUM_REGS];
    logic [7:0]  n_regs [NUM_REGS];
    logic        r_half;
    logic [15:0] r_noise_cnt;
    logic [15:0] n_noise_cnt;
    logic [16:0] r_lfsr;
    logic [16:0] n_lfsr;
    logic [20:0] r_env_cnt;
    logic [20:0] n_env_cnt;
    t_env_state  r_env;
    t_env_state  n_env;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic        w_accept;
    logic [1:0]  w_cmd;
    logic [3:0]  w_addr;
    logic [7:0]  w_data;
    logic        w_work;
    logic [4:0]  w_noise_raw;
    logic [15:0] w_noise_per;
    logic [15:0] w_env_raw;
    logic [20:0] w_env_per;
    logic        w_env_step;
    t_env_state  w_env_adv;
    t_env_evt    w_env_evt;
    logic [3:0]  w_level [NUM_LANES];

    assign w_cmd  = i_s_axis_tuser;
    assign w_addr = i_s_axis_tdata[3:0];
    assign w_data = i_s_axis_tdata[11:4];

    // accept whenever the output register is free or draining
    assign o_s_axis_tready = i_rst_n & (~r_out_valid | i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    // divide ticks by two: work on the tick that returns the phase to zero
    assign w_work = w_accept && (w_cmd == CMD_TICK) && r_half;

    // register file write
    always_comb begin
        n_regs = r_regs;
        if (w_accept && (w_cmd == CMD_WRITE)) begin
            n_regs[w_addr] = w_data;
        end
    end

    // noise: period in units of 16, zero acts as one; whole byte zero halts it
    assign w_noise_raw = r_regs[REG_NOISE][4:0];
    assign w_noise_per = {7'd0, ((w_noise_raw == 5'd0) ? 5'd1 : w_noise_raw), 4'b0000};

    always_comb begin
        n_noise_cnt = r_noise_cnt;
        n_lfsr      = r_lfsr;
        if (w_work && (r_regs[REG_NOISE] != 8'd0)) begin
            if (r_noise_cnt >= w_noise_per) begin
                n_lfsr      = {r_lfsr[0] ^ r_lfsr[3], r_lfsr[16:1]};
                n_noise_cnt = 16'd1;
            end else begin
                n_noise_cnt = r_noise_cnt + 16'd1;
            end
        end
    end

    // envelope: period in units of 16, zero acts as one
    assign w_env_raw  = {r_regs[REG_ENV_COARSE], r_regs[REG_ENV_FINE]};
    assign w_env_per  = {1'b0, ((w_env_raw == 16'd0) ? 16'd1 : w_env_raw), 4'b0000};
    assign w_env_step = (r_env_cnt >= w_env_per);
    assign w_env_adv  = env_advance(r_env, r_regs[REG_SHAPE]);

    always_comb begin
        n_env     = r_env;
        n_env_cnt = r_env_cnt;
        if (w_accept && (w_cmd == CMD_RESTART)) begin
            // restart loads direction and level only; counter keeps running
            if (r_regs[REG_SHAPE][SHAPE_ATTACK]) begin
                n_env.dir   = DIR_UP;
                n_env.level = LVL_MIN;
            end else begin
                n_env.dir   = DIR_DOWN;
                n_env.level = LVL_MAX;
            end
        end else if (w_work) begin
            if (w_env_step) begin
                n_env     = w_env_adv;
                n_env_cnt = 21'd1;
            end else begin
                n_env_cnt = r_env_cnt + 21'd1;
            end
        end
    end

    assign w_env_evt.step  = w_env_step;
    assign w_env_evt.level = w_env_adv.level;

    // channel lanes; absent channels report zero
    for (genvar gi = 0; gi < NUM_LANES; gi++) begin : g_lane
        if (gi < CHANNELS) begin : g_on
            logic       w_square;
            logic [3:0] w_volume;
            logic       w_pass;

            psg_tone u_tone (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_work        (w_work),
                .i_fine        (r_regs[4'(2 * gi)]),
                .i_coarse      (r_regs[4'(2 * gi + 1)][3:0]),
                .i_amp         (r_regs[REG_AMP_BASE + 4'(gi)][4:0]),
                .i_env         (w_env_evt),
                .o_square_next (w_square),
                .o_volume_next (w_volume)
            );

            // mixer: a disabled source passes
            assign w_pass = (w_square | n_regs[REG_MIXER][gi]) &
                            (n_lfsr[0] | n_regs[REG_MIXER][gi + 3]);
            assign w_level[gi] = w_pass ? w_volume : 4'd0;
        end else begin : g_off
            assign w_level[gi] = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[4'(i)] <= 8'd0;
            end
            r_half      <= 1'b0;
            r_noise_cnt <= '0;
            r_lfsr      <= 17'd1;
            r_env_cnt   <= '0;
            r_env       <= '{dir: DIR_STOP, level: LVL_MIN};
            r_out_valid <= 1'b0;
        end else begin
            r_regs      <= n_regs;
            r_noise_cnt <= n_noise_cnt;
            r_lfsr      <= n_lfsr;
            r_env_cnt   <= n_env_cnt;
            r_env       <= n_env;
            if (w_accept && (w_cmd == CMD_TICK)) begin
                r_half <= ~r_half;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word register, loaded on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {4'd0, w_level[2], w_level[1], w_level[0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ hw/rtl/psg_chk.sv @@
// ----------------------------------------------------------------------------
// psg_chk
// Port-level checker for the sound generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "psg_tone_noise_envelope_macros.svh"

module psg_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata
);

    `PSG_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)
    `PSG_ASSERT_NEXT(a_word_out, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, o_m_axis_tvalid)
    `PSG_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[15:12] == 4'd0)
    `PSG_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `PSG_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata))

endmodule

bind psg_tone_noise_envelope psg_chk u_psg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
